@@ src/chd_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, command and result codes for the canonical huffman decoder
// no dependencies
package chd_pkg;

    localparam int MAX_SYMBOLS_DEF = 1024;
    localparam int MAX_LEN         = 63;
    localparam int LEN_W           = 6;
    localparam int CODE_W          = 63;
    localparam int ALPHA_W         = 11;
    localparam int SYM_OUT_W       = 10;
    localparam int KIND_W          = 3;
    localparam int CMD_W           = 2;
    localparam int LEN_SLOTS       = 64;
    localparam int LEFT_W          = 33;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 11'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_BUILD  = 2'd1,
        CMD_DECODE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_SYMBOL  = 3'd0,
        KIND_INVALID = 3'd1,
        KIND_BUILD_OK = 3'd2,
        KIND_OVERSUB = 3'd3,
        KIND_REJECT  = 3'd4
    } t_kind;

endpackage

@@ src/chd_ram.sv @@
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module chd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/canonical_huffman_decoder_core.sv @@
`timescale 1ns / 1ps
// canonical huffman decoder top level: control sequencer and table memories
// depends on chd_pkg and chd_ram
//
// One request is processed at a time. An accepted load leaves the sequencer
// idle and a rejected load passes through the output stage. A decode bit with
// no result goes back to idle after the compare; an invalid-stream result
// goes straight to the output stage when nothing is built or the accumulator
// is full, and after the compare when the code is out of reach; a symbol goes
// there after the compare and a registered read of the sorted symbol memory.
// The compare uses registered reads of the per-length tables, and a result
// waits in the output stage until the output register is free. A build is a
// 64-entry count clear, two passes over the length memory with a
// read-modify-write of a count or fill pointer for each used entry, a 63-entry
// table sweep and a 63-entry reach-limit sweep. An oversubscribed build stops
// inside the table sweep. After reset and after a clear request the length
// memory is zeroed one entry per cycle, during which no request is taken;
// configuration writes are always taken.
module canonical_huffman_decoder_core
    import chd_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [ALPHA_W-1:0]   i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [9:0]           i_entry_symbol,
    input  logic [LEN_W-1:0]     i_entry_length,
    input  logic                 i_stream_bit,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [KIND_W-1:0]    o_kind,
    output logic [SYM_OUT_W-1:0] o_symbol_out,
    output logic [LEN_W-1:0]     o_code_bits
);

    localparam int SYM_W = $clog2(MAX_SYMBOLS);
    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int TAB_W = 2 * CNT_W + CODE_W;
    localparam int SLOT_W = $clog2(LEN_SLOTS);
    localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(MAX_SYMBOLS - 1);
    localparam logic [LEFT_W:0] KRAFT_CAP = (LEFT_W + 1)'(64'h1_0000_0000);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_EMIT,
        S_CCLR, S_RLEN, S_WLEN, S_RCNT,
        S_KR0, S_KR, S_LIM,
        S_SRLEN, S_SWLEN, S_SFILL,
        S_DCMP, S_DSYM
    } t_state;

    t_state r_state;

    logic [ALPHA_W-1:0]   r_alpha;
    logic [SYM_W-1:0]     r_idx;
    logic [SLOT_W-1:0]    r_l;
    logic [LEFT_W-1:0]    r_left;
    logic [CODE_W-1:0]    r_code;
    logic [CNT_W-1:0]     r_base;
    logic [CNT_W-1:0]     r_prev;
    logic [SLOT_W-1:0]    r_maxlen;
    logic [CODE_W-1:0]    r_last;
    logic [CODE_W-1:0]    r_sh;
    logic [CODE_W-1:0]    r_acc;
    logic [LEN_W-1:0]     r_bits;
    logic                 r_built;
    logic [KIND_W-1:0]    r_pkind;
    logic [SYM_OUT_W-1:0] r_psym;
    logic [LEN_W-1:0]     r_pbits;
    logic                 r_out_valid;
    logic [KIND_W-1:0]    r_kind;
    logic [SYM_OUT_W-1:0] r_sym;
    logic [LEN_W-1:0]     r_cbits;

    // memory ports
    logic             len_we;
    logic [SYM_W-1:0] len_waddr;
    logic [LEN_W-1:0] len_wdata;
    logic [LEN_W-1:0] len_rdata;
    logic              aux_we;
    logic [SLOT_W-1:0] aux_waddr;
    logic [CNT_W-1:0]  aux_wdata;
    logic [SLOT_W-1:0] aux_raddr;
    logic [CNT_W-1:0]  aux_rdata;
    logic              tab_we;
    logic [TAB_W-1:0]  tab_wdata;
    logic [TAB_W-1:0]  tab_rdata;
    logic              lim_we;
    logic [CODE_W-1:0] lim_wdata;
    logic [CODE_W-1:0] lim_rdata;
    logic              sym_we;
    logic [SYM_W-1:0]  sym_waddr;
    logic [SYM_W-1:0]  sym_raddr;
    logic [SYM_W-1:0]  sym_rdata;

    logic              accept;
    logic              slot_free;
    logic              load_bad;
    logic [SLOT_W-1:0] tab_raddr;
    logic [CNT_W-1:0]  tab_cnt;
    logic [CODE_W-1:0] tab_first;
    logic [CNT_W-1:0]  tab_base;
    logic [CODE_W-1:0] diff;
    logic              hit;
    logic [LEFT_W:0]   left2x;
    logic [LEFT_W-1:0] left2;
    logic              oversub;
    logic [CODE_W-1:0] code_n;
    logic [CNT_W-1:0]  base_n;
    logic              fill_ok;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign load_bad   = (i_entry_length == '0)
                     || ({1'b0, i_entry_symbol} >= r_alpha)
                     || (32'(i_entry_symbol) >= MAX_SYMBOLS);

    // decode compare against the row for the current length
    assign tab_raddr = SLOT_W'(r_bits + 1'b1);
    assign tab_cnt   = tab_rdata[TAB_W-1 -: CNT_W];
    assign tab_first = tab_rdata[CNT_W +: CODE_W];
    assign tab_base  = tab_rdata[CNT_W-1:0];
    assign diff      = r_acc - tab_first;
    assign hit       = (tab_cnt != '0) && (r_acc >= tab_first)
                    && (diff < CODE_W'(tab_cnt));
    assign sym_raddr = SYM_W'(tab_base + diff[CNT_W-1:0]);

    // kraft check and canonical first code per length
    assign left2x  = {r_left, 1'b0};
    assign left2   = (left2x > KRAFT_CAP) ? LEFT_W'(KRAFT_CAP) : LEFT_W'(left2x);
    assign oversub = LEFT_W'(aux_rdata) > left2;
    assign code_n  = (r_code + CODE_W'(r_prev)) << 1;
    assign base_n  = r_base + r_prev;
    assign tab_wdata = {aux_rdata, code_n, base_n};
    assign fill_ok = 32'(aux_rdata) < MAX_SYMBOLS;

    always_comb begin
        len_we    = 1'b0;
        len_waddr = r_idx;
        len_wdata = '0;
        aux_we    = 1'b0;
        aux_waddr = r_l;
        aux_wdata = '0;
        aux_raddr = r_l;
        tab_we    = 1'b0;
        lim_we    = 1'b0;
        lim_wdata = '0;
        sym_we    = 1'b0;
        sym_waddr = SYM_W'(aux_rdata);
        case (r_state)
            S_CLR: begin
                len_we = 1'b1;
            end
            S_IDLE: begin
                if (accept && t_cmd'(i_cmd) == CMD_LOAD && !load_bad) begin
                    len_we    = 1'b1;
                    len_waddr = SYM_W'(i_entry_symbol);
                    len_wdata = i_entry_length;
                end
            end
            S_CCLR: begin
                aux_we = 1'b1;
            end
            S_WLEN, S_SWLEN: begin
                aux_raddr = SLOT_W'(len_rdata);
            end
            S_RCNT: begin
                aux_we    = 1'b1;
                aux_wdata = aux_rdata + 1'b1;
            end
            S_KR0: begin
                aux_raddr = SLOT_W'(1);
            end
            S_KR: begin
                aux_raddr = r_l + 1'b1;
                if (!oversub) begin
                    tab_we    = 1'b1;
                    aux_we    = 1'b1;
                    aux_wdata = base_n;
                end
            end
            S_LIM: begin
                lim_we = 1'b1;
                // the longest length takes the last code plus one, shorter ones its prefix plus one, longer ones zero
                if (r_l > r_maxlen) begin
                    lim_wdata = '0;
                end else if (r_l == r_maxlen) begin
                    lim_wdata = r_last + 1'b1;
                end else begin
                    lim_wdata = r_sh + 1'b1;
                end
            end
            S_SFILL: begin
                if (fill_ok) begin
                    sym_we    = 1'b1;
                    aux_we    = 1'b1;
                    aux_wdata = aux_rdata + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_alpha     <= ALPHA_RST;
            r_acc       <= '0;
            r_bits      <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_alpha <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_SYM) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_psym  <= '0;
                        r_pbits <= '0;
                        case (t_cmd'(i_cmd))
                            CMD_LOAD: begin
                                if (load_bad) begin
                                    r_pkind <= KIND_REJECT;
                                    r_state <= S_EMIT;
                                end
                            end
                            CMD_BUILD: begin
                                r_acc   <= '0;
                                r_bits  <= '0;
                                r_l     <= '0;
                                r_state <= S_CCLR;
                            end
                            CMD_CLEAR: begin
                                r_acc   <= '0;
                                r_bits  <= '0;
                                r_built <= 1'b0;
                                r_idx   <= '0;
                                r_state <= S_CLR;
                            end
                            default: begin
                                r_pkind <= KIND_INVALID;
                                if (!r_built || r_bits >= LEN_W'(MAX_LEN)) begin
                                    r_acc   <= '0;
                                    r_bits  <= '0;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_acc   <= {r_acc[CODE_W-2:0], i_stream_bit};
                                    r_bits  <= r_bits + 1'b1;
                                    r_state <= S_DCMP;
                                end
                            end
                        endcase
                    end
                end
                S_DCMP: begin
                    if (hit) begin
                        r_pkind <= KIND_SYMBOL;
                        r_pbits <= r_bits;
                        r_acc   <= '0;
                        r_bits  <= '0;
                        r_state <= S_DSYM;
                    end else if (r_acc >= lim_rdata) begin
                        r_acc   <= '0;
                        r_bits  <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DSYM: begin
                    r_psym  <= SYM_OUT_W'(sym_rdata);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= r_pkind;
                        r_sym       <= r_psym;
                        r_cbits     <= r_pbits;
                        r_state     <= S_IDLE;
                    end
                end
                // count symbols per length
                S_CCLR: begin
                    r_l <= r_l + 1'b1;
                    if (r_l == SLOT_W'(LEN_SLOTS - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_RLEN;
                    end
                end
                S_RLEN: begin
                    r_state <= S_WLEN;
                end
                S_WLEN, S_RCNT: begin
                    if (r_state == S_WLEN && len_rdata != '0) begin
                        r_l     <= SLOT_W'(len_rdata);
                        r_state <= S_RCNT;
                    end else if (r_idx == LAST_SYM) begin
                        r_state <= S_KR0;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RLEN;
                    end
                end
                // kraft check, first codes and bases
                S_KR0: begin
                    r_l      <= SLOT_W'(1);
                    r_left   <= LEFT_W'(1);
                    r_code   <= '0;
                    r_base   <= '0;
                    r_prev   <= '0;
                    r_maxlen <= '0;
                    r_last   <= '0;
                    r_state  <= S_KR;
                end
                S_KR: begin
                    if (oversub) begin
                        r_built <= 1'b0;
                        r_pkind <= KIND_OVERSUB;
                        r_state <= S_EMIT;
                    end else begin
                        r_left <= left2 - LEFT_W'(aux_rdata);
                        r_code <= code_n;
                        r_base <= base_n;
                        r_prev <= aux_rdata;
                        if (aux_rdata != '0) begin
                            r_maxlen <= r_l;
                            r_last   <= code_n + CODE_W'(aux_rdata) - 1'b1;
                        end
                        if (r_l == SLOT_W'(MAX_LEN)) begin
                            r_l     <= SLOT_W'(MAX_LEN);
                            r_state <= S_LIM;
                        end else begin
                            r_l <= r_l + 1'b1;
                        end
                    end
                end
                // reach limits, longest length first
                S_LIM: begin
                    if (r_l == r_maxlen) begin
                        r_sh <= r_last >> 1;
                    end else if (r_l < r_maxlen) begin
                        r_sh <= r_sh >> 1;
                    end
                    r_l <= r_l - 1'b1;
                    if (r_l == SLOT_W'(1)) begin
                        r_idx   <= '0;
                        r_state <= S_SRLEN;
                    end
                end
                // place symbols in canonical order
                S_SRLEN: begin
                    r_state <= S_SWLEN;
                end
                S_SWLEN, S_SFILL: begin
                    if (r_state == S_SWLEN && len_rdata != '0) begin
                        r_l     <= SLOT_W'(len_rdata);
                        r_state <= S_SFILL;
                    end else if (r_idx == LAST_SYM) begin
                        r_built <= 1'b1;
                        r_pkind <= KIND_BUILD_OK;
                        r_state <= S_EMIT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SRLEN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    chd_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SYMBOLS)) u_len_ram (
        .i_clk  (i_clk),
        .i_we   (len_we),
        .i_waddr(len_waddr),
        .i_wdata(len_wdata),
        .i_raddr(r_idx),
        .o_rdata(len_rdata)
    );

    chd_ram #(.WIDTH(CNT_W), .DEPTH(LEN_SLOTS)) u_aux_ram (
        .i_clk  (i_clk),
        .i_we   (aux_we),
        .i_waddr(aux_waddr),
        .i_wdata(aux_wdata),
        .i_raddr(aux_raddr),
        .o_rdata(aux_rdata)
    );

    chd_ram #(.WIDTH(TAB_W), .DEPTH(LEN_SLOTS)) u_tab_ram (
        .i_clk  (i_clk),
        .i_we   (tab_we),
        .i_waddr(r_l),
        .i_wdata(tab_wdata),
        .i_raddr(tab_raddr),
        .o_rdata(tab_rdata)
    );

    chd_ram #(.WIDTH(CODE_W), .DEPTH(LEN_SLOTS)) u_lim_ram (
        .i_clk  (i_clk),
        .i_we   (lim_we),
        .i_waddr(r_l),
        .i_wdata(lim_wdata),
        .i_raddr(tab_raddr),
        .o_rdata(lim_rdata)
    );

    chd_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SYMBOLS)) u_sym_ram (
        .i_clk  (i_clk),
        .i_we   (sym_we),
        .i_waddr(sym_waddr),
        .i_wdata(r_idx),
        .i_raddr(sym_raddr),
        .o_rdata(sym_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_symbol_out = r_sym;
    assign o_code_bits  = r_cbits;

    a_sym_has_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_SYMBOL |-> o_code_bits != '0)
        else $error("decoded symbol with zero code length");

    a_other_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_SYMBOL |-> o_symbol_out == '0 && o_code_bits == '0)
        else $error("non-symbol result carries payload");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && t_cmd'(i_cmd) != CMD_LOAD |=> !o_in_ready)
        else $error("request taken while previous one still in work");

    a_bits_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && r_pkind != KIND_REJECT |-> r_bits == '0)
        else $error("accumulator not cleared with result");

endmodule

@@ tb/canonical_huffman_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for canonical_huffman_decoder_core: codebook loads, builds,
// bit-serial decoding and clears checked against an in-bench predictor
// depends on chd_pkg and the decoder core rtl
module canonical_huffman_decoder_core_tb
    import chd_pkg::*;
();

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SYM_OUT_W-1:0] sym;
        logic [LEN_W-1:0]     bits;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [ALPHA_W-1:0]   i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [CMD_W-1:0]     i_cmd = CMD_LOAD;
    logic [9:0]           i_entry_symbol = '0;
    logic [LEN_W-1:0]     i_entry_length = '0;
    logic                 i_stream_bit = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [KIND_W-1:0]    o_kind;
    logic [SYM_OUT_W-1:0] o_symbol_out;
    logic [LEN_W-1:0]     o_code_bits;

    canonical_huffman_decoder_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_cmd(i_cmd), .i_entry_symbol(i_entry_symbol),
        .i_entry_length(i_entry_length), .i_stream_bit(i_stream_bit),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_kind(o_kind), .o_symbol_out(o_symbol_out), .o_code_bits(o_code_bits)
    );

    always #10 i_clk = ~i_clk;

    // decoder shadow state
    logic [5:0]  len_mem [1024];
    int unsigned len_count [64];
    logic [63:0] first_code [64];
    int unsigned len_base [64];
    logic [63:0] reach [64];
    logic [9:0]  sorted_sym [1024];
    logic [62:0] acc;
    int          nbits;
    bit          built;
    int unsigned alpha;
    int unsigned assigned;

    t_result expected_q [$];
    int n_sent, n_results, n_builds, n_errors;
    bit sender_burst;
    bit hold_req;

    function automatic bit build_tables();
        logic [63:0] left, code, last;
        int unsigned fill [64];
        int unsigned base;
        int maxl;
        left = 1; code = 0; base = 0; maxl = 0;
        foreach (len_count[l]) len_count[l] = 0;
        for (int s = 0; s < 1024; s++)
            if (len_mem[s] != 0) len_count[len_mem[s]]++;
        for (int l = 1; l <= MAX_LEN; l++) begin
            left = left << 1;
            if (left > 64'h1_0000_0000) left = 64'h1_0000_0000;
            if (len_count[l] > left) return 1'b0;
            left -= len_count[l];
        end
        first_code[0] = 0;
        len_base[0] = 0;
        for (int l = 1; l < LEN_SLOTS; l++) begin
            code = (code + len_count[l-1]) << 1;
            base += len_count[l-1];
            first_code[l] = code;
            len_base[l] = base;
            fill[l] = base;
            if (len_count[l] != 0) maxl = l;
        end
        for (int s = 0; s < 1024; s++)
            if (len_mem[s] != 0 && fill[len_mem[s]] < 1024) begin
                sorted_sym[fill[len_mem[s]]] = s[9:0];
                fill[len_mem[s]]++;
            end
        foreach (reach[l]) reach[l] = 0;
        if (maxl != 0) begin
            last = first_code[maxl] + len_count[maxl] - 1;
            for (int l = 1; l <= maxl; l++) reach[l] = (last >> (maxl - l)) + 1;
        end
        assigned = base + len_count[63];
        return 1'b1;
    endfunction

    function automatic bit predict_step(input t_cmd cmd, input logic [9:0] sym,
                                        input logic [5:0] len, input logic bitv,
                                        output t_result r);
        logic [63:0] a;
        r = '0;
        case (cmd)
            CMD_LOAD: begin
                if (len == 0 || sym >= alpha) begin
                    r.kind = KIND_REJECT;
                    return 1'b1;
                end
                len_mem[sym] = len;
                return 1'b0;
            end
            CMD_BUILD: begin
                acc = 0; nbits = 0;
                built = build_tables();
                r.kind = built ? KIND_BUILD_OK : KIND_OVERSUB;
                return 1'b1;
            end
            CMD_CLEAR: begin
                foreach (len_mem[s]) len_mem[s] = 0;
                built = 0; acc = 0; nbits = 0;
                return 1'b0;
            end
            default: begin
                if (!built || nbits >= MAX_LEN) begin
                    acc = 0; nbits = 0;
                    r.kind = KIND_INVALID;
                    return 1'b1;
                end
                acc = {acc[61:0], bitv};
                nbits++;
                a = {1'b0, acc};
                if (len_count[nbits] != 0 && a >= first_code[nbits] &&
                    a - first_code[nbits] < len_count[nbits]) begin
                    r.kind = KIND_SYMBOL;
                    r.sym = sorted_sym[len_base[nbits] + (a - first_code[nbits])];
                    r.bits = nbits[5:0];
                    acc = 0; nbits = 0;
                    return 1'b1;
                end
                if (a >= reach[nbits]) begin
                    acc = 0; nbits = 0;
                    r.kind = KIND_INVALID;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // one request; unused fields carry random values
    task automatic send_request(input t_cmd cmd, input int sym, input int len, input bit b);
        t_result r;
        logic [9:0] s;
        logic [5:0] l;
        s = (cmd == CMD_LOAD) ? sym[9:0] : 10'($urandom);
        l = (cmd == CMD_LOAD) ? len[5:0] : 6'($urandom);
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_entry_symbol <= s;
        i_entry_length <= l;
        i_stream_bit <= (cmd == CMD_DECODE) ? b : 1'($urandom);
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
        if (predict_step(cmd, s, l, (cmd == CMD_DECODE) ? b : 1'b0, r))
            expected_q = {expected_q, r};
        if (cmd == CMD_BUILD) n_builds++;
        if (!sender_burst && $urandom_range(0, 99) < 28) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_alphabet(input int v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v[ALPHA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        alpha = v;
    endtask

    // emits the code of a randomly chosen assigned symbol, msb first
    task automatic send_codeword();
        int k, len;
        logic [63:0] code;
        if (assigned == 0) begin
            send_request(CMD_DECODE, 0, 0, 1'($urandom));
            return;
        end
        k = $urandom_range(0, assigned - 1);
        len = 1;
        for (int l = 1; l <= MAX_LEN; l++)
            if (k >= len_base[l] && k < len_base[l] + len_count[l]) len = l;
        code = first_code[len] + (k - len_base[len]);
        for (int i = len - 1; i >= 0; i--) send_request(CMD_DECODE, 0, 0, code[i]);
    endtask

    task automatic decode_run(input int n);
        for (int i = 0; i < n; i++)
            if (built && $urandom_range(0, 99) < 80) send_codeword();
            else send_request(CMD_DECODE, 0, 0, 1'($urandom));
    endtask

    task automatic test_directed();
        send_request(CMD_DECODE, 0, 0, 1);       // decode with nothing built
        send_request(CMD_LOAD, 5, 0, 0);         // zero length
        send_request(CMD_LOAD, 1023, 4, 0);      // symbol beyond alphabet
        send_request(CMD_BUILD, 0, 0, 0);        // empty codebook
        send_request(CMD_DECODE, 0, 0, 0);
        send_request(CMD_LOAD, 0, 1, 0);
        send_request(CMD_LOAD, 255, 2, 0);
        send_request(CMD_LOAD, 7, 63, 0);
        send_request(CMD_LOAD, 7, 3, 0);         // replaces earlier length
        send_request(CMD_BUILD, 0, 0, 0);
        for (int i = 0; i < 5; i++) send_request(CMD_DECODE, 0, 0, i < 2);
        send_request(CMD_LOAD, 9, 1, 0);         // second length-1 code oversubscribes the code space
        send_request(CMD_BUILD, 0, 0, 0);
        send_request(CMD_DECODE, 0, 0, 0);
        send_request(CMD_CLEAR, 0, 0, 0);
        send_request(CMD_DECODE, 0, 0, 1);
        set_alphabet(1);
        send_request(CMD_LOAD, 0, 63, 0);
        send_request(CMD_LOAD, 1, 5, 0);
        send_request(CMD_BUILD, 0, 0, 0);
        for (int i = 0; i < 63; i++) send_request(CMD_DECODE, 0, 0, 0);
        set_alphabet(1024);
        send_request(CMD_LOAD, 1023, 42, 0);
        send_request(CMD_LOAD, 512, 21, 0);
    endtask

    // lengths in [minl, minl+3] with at most 2^minl symbols fit the code space
    task automatic random_codebook();
        int minl, n, s;
        case ($urandom_range(0, 5))
            0: set_alphabet(1);
            1: set_alphabet(1024);
            2: set_alphabet($urandom_range(2, 1023));
            default: ;
        endcase
        send_request(CMD_CLEAR, 0, 0, 0);
        minl = $urandom_range(1, 6);
        n = $urandom_range(1, (1 << minl) < 40 ? (1 << minl) : 40);
        if ($urandom_range(0, 7) == 0) n = (1 << minl) + $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            s = $urandom_range(0, alpha - 1);
            case ($urandom_range(0, 19))
                0: send_request(CMD_LOAD, $urandom_range(0, 1023), 0, 0);
                1: send_request(CMD_LOAD, $urandom_range(alpha < 1024 ? alpha : 1023, 1023),
                                minl, 0);
                default:
                    send_request(CMD_LOAD, s, (n > (1 << minl)) ? minl
                                 : minl + $urandom_range(0, 3), 0);
            endcase
        end
        send_request(CMD_BUILD, 0, 0, 0);
        decode_run($urandom_range(20, 45));
        // loads after a build leave the tables in use
        send_request(CMD_LOAD, $urandom_range(0, alpha - 1), $urandom_range(1, 63), 0);
        decode_run(8);
    endtask

    // chain of lengths 1..63, complete code space, deep codes
    task automatic test_long_codes();
        set_alphabet(1024);
        send_request(CMD_CLEAR, 0, 0, 0);
        for (int l = 1; l <= 62; l++) send_request(CMD_LOAD, 1023 - 16 * l, l, 0);
        send_request(CMD_LOAD, 1, 63, 0);
        send_request(CMD_LOAD, 1023, 63, 0);
        send_request(CMD_BUILD, 0, 0, 0);
        decode_run(6);
        for (int i = 0; i < 63; i++) send_request(CMD_DECODE, 0, 0, 1);
        for (int i = 0; i < 63; i++) send_request(CMD_DECODE, 0, 0, i < 62);
    endtask

    task automatic test_backpressure();
        sender_burst = 1'b1;
        hold_req = ~hold_req;
        decode_run(60);
        sender_burst = 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result kind=%0d sym=%0d bits=%0d",
                             o_kind, o_symbol_out, o_code_bits);
            end else begin
                e = expected_q.pop_front();
                if (e.kind !== o_kind || e.sym !== o_symbol_out || e.bits !== o_code_bits) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: expected kind=%0d sym=%0d bits=%0d, got %0d %0d %0d",
                                 e.kind, e.sym, e.bits, o_kind, o_symbol_out, o_code_bits);
                end
            end
        end
    end

    // receiver: random stalls, calm windows, and a long hold on request
    int rx_cycle, hold_left;
    bit hold_seen;
    always @(posedge i_clk) begin
        rx_cycle++;
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 300;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (rx_cycle % 3000 < 400) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= 28);
        end
    end

    initial begin
        #(20 * 4_000_000);
        $display("[canonical_huffman_decoder_core] ERROR");
        $finish;
    end

    initial begin
        foreach (len_mem[s]) len_mem[s] = 0;
        foreach (len_count[l]) len_count[l] = 0;
        foreach (reach[l]) reach[l] = 0;
        acc = 0; nbits = 0; built = 0; alpha = ALPHA_RST; assigned = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_long_codes();
        while (n_sent < 1050) random_codebook();
        test_backpressure();
        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("requests sent %0d, results checked %0d, builds %0d, mismatches %0d",
                 n_sent, n_results, n_builds, n_errors);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("[canonical_huffman_decoder_core] OK");
        else
            $display("[canonical_huffman_decoder_core] ERROR");
        $finish;
    end

endmodule

@@ canonical_huffman_decoder_core.f @@
src/chd_pkg.sv
src/chd_ram.sv
src/canonical_huffman_decoder_core.sv
tb/canonical_huffman_decoder_core_tb.sv
